// ----- rtl/hvps_pkg.sv -----
// Shared types and constants for the humidifier valve and pump sequencer.
// Holds the configuration, classification and result structs and the code constants.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hvps_pkg;

    // Widths of the shared countdown, the debounce run counters and the other fields.
    localparam int TIMER_BITS = 12;
    localparam int RUN_BITS   = 8;
    localparam int HUM_BITS   = 11;
    localparam int DUTY_BITS  = 8;
    localparam int CFG_BITS   = 12;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESET    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VALVE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUMP_RUN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUMP_WAIT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY      = 3'd5;

    // Reset values of the configuration registers.
    localparam logic signed [HUM_BITS-1:0] PRESET_RST    = 11'sd500;
    localparam logic [RUN_BITS-1:0]        DEBOUNCE_RST  = 8'd10;
    localparam logic [TIMER_BITS-1:0]      VALVE_RST     = 12'd180;
    localparam logic [TIMER_BITS-1:0]      PUMP_RUN_RST  = 12'd60;
    localparam logic [TIMER_BITS-1:0]      PUMP_WAIT_RST = 12'd60;
    localparam logic [DUTY_BITS-1:0]       DUTY_RST      = 8'd217;

    // Pump phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [HUM_BITS-1:0] rh_setpoint;
        logic [RUN_BITS-1:0]        settle_count;
        logic [TIMER_BITS-1:0]      valve_fill_ticks;
        logic [TIMER_BITS-1:0]      pump_run_ticks;
        logic [TIMER_BITS-1:0]      pump_wait_ticks;
        logic [DUTY_BITS-1:0]       pump_run_duty;
    } t_cfg;

    // One classified tick, passed from the front to the back.
    typedef struct packed {
        logic water_empty;
        logic target;
    } t_cls;

    // One result item.
    typedef struct packed {
        logic                  valve_open;
        logic [DUTY_BITS-1:0]  pump_duty;
        logic                  water_empty;
        logic [1:0]            pump_phase;
        logic [TIMER_BITS-1:0] ticks_left;
        logic                  target_reached;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/humidifier_valve_pump_sequencer.sv -----
// Humidifier valve and pump sequencer.
// Usage: each request on the input queue port is one one-second tick carrying the
// raw tank sense bit and the corrected humidity in tenths of a percent. The
// tick is accepted at a rising edge with push high and full low. Each tick
// produces exactly one result, presented while empty is low and taken at a
// rising edge with pop high.
// Configuration: six registers written through i_cfg_we / i_cfg_idx /
// i_cfg_data; indexes above five are ignored. The user must write them only
// while no tick is in flight; the block itself does not enforce this.
// Flow: on acceptance the front debounce result enters the classification
// queue; the control step then moves it into the result queue, whose head
// drives the output ports. Throughput: one tick per cycle while pop stays
// high; both queues hold two entries.
// Stalls: when pop is held low the result queue fills, the back end stops,
// the classification queue fills and full rises; nothing is lost.
// Reset: synchronous active-low reset empties both queues, clears debounce
// and control state and loads the register defaults.
// Depends on hvps_pkg, hvps_front, hvps_cls_queue, hvps_back, hvps_res_queue.
`timescale 1ns / 1ps
`default_nettype none

module humidifier_valve_pump_sequencer (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  i_tank_sense_high,
    input  wire logic signed [hvps_pkg::HUM_BITS-1:0]  i_humidity_tenths,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic                                       o_valve_open,
    output logic [hvps_pkg::DUTY_BITS-1:0]             o_pump_duty,
    output logic                                       o_water_empty,
    output logic [1:0]                                 o_pump_phase,
    output logic [hvps_pkg::TIMER_BITS-1:0]            o_ticks_left,
    output logic                                       o_target_reached,
    input  wire logic                                  i_cfg_we,
    input  wire logic [hvps_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [hvps_pkg::CFG_BITS-1:0]         i_cfg_data
);

    hvps_pkg::t_cfg    r_cfg;
    hvps_pkg::t_cls    front_cls;
    hvps_pkg::t_cls    cls_head;
    hvps_pkg::t_result back_result;
    hvps_pkg::t_result res_head;
    logic              take;
    logic              cls_empty;
    logic              res_full;
    logic              back_go;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rh_setpoint      <= hvps_pkg::PRESET_RST;
            r_cfg.settle_count     <= hvps_pkg::DEBOUNCE_RST;
            r_cfg.valve_fill_ticks <= hvps_pkg::VALVE_RST;
            r_cfg.pump_run_ticks   <= hvps_pkg::PUMP_RUN_RST;
            r_cfg.pump_wait_ticks  <= hvps_pkg::PUMP_WAIT_RST;
            r_cfg.pump_run_duty    <= hvps_pkg::DUTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hvps_pkg::CFG_PRESET:
                    r_cfg.rh_setpoint <= signed'(i_cfg_data[hvps_pkg::HUM_BITS-1:0]);
                hvps_pkg::CFG_DEBOUNCE:
                    r_cfg.settle_count <= i_cfg_data[hvps_pkg::RUN_BITS-1:0];
                hvps_pkg::CFG_VALVE:
                    r_cfg.valve_fill_ticks <= i_cfg_data[hvps_pkg::TIMER_BITS-1:0];
                hvps_pkg::CFG_PUMP_RUN:
                    r_cfg.pump_run_ticks <= i_cfg_data[hvps_pkg::TIMER_BITS-1:0];
                hvps_pkg::CFG_PUMP_WAIT:
                    r_cfg.pump_wait_ticks <= i_cfg_data[hvps_pkg::TIMER_BITS-1:0];
                hvps_pkg::CFG_DUTY:
                    r_cfg.pump_run_duty <= i_cfg_data[hvps_pkg::DUTY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input request handshake.
    assign take = push && !full;

    hvps_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (take),
        .i_tank_sense_high (i_tank_sense_high),
        .i_humidity_tenths (i_humidity_tenths),
        .i_cfg             (r_cfg),
        .o_cls             (front_cls)
    );

    hvps_cls_queue u_cls_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (back_go),
        .o_full  (full),
        .o_empty (cls_empty),
        .o_head  (cls_head)
    );

    // The back end steps when a tick waits and the result queue has room.
    assign back_go = !cls_empty && !res_full;

    hvps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (back_go),
        .i_cls    (cls_head),
        .i_cfg    (r_cfg),
        .o_result (back_result)
    );

    hvps_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_go),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_full  (res_full),
        .o_empty (empty),
        .o_head  (res_head)
    );

    // Result fields.
    assign o_valve_open     = res_head.valve_open;
    assign o_pump_duty      = res_head.pump_duty;
    assign o_water_empty    = res_head.water_empty;
    assign o_pump_phase     = res_head.pump_phase;
    assign o_ticks_left     = res_head.ticks_left;
    assign o_target_reached = res_head.target_reached;

endmodule

`default_nettype wire

// ----- rtl/hvps_front.sv -----
// Front end: debounces the tank sense bit and compares humidity with the preset.
// Depends on hvps_pkg for the configuration and classification types.
`timescale 1ns / 1ps
`default_nettype none

module hvps_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire logic                          i_tank_sense_high,
    input  wire logic signed [hvps_pkg::HUM_BITS-1:0] i_humidity_tenths,
    input  wire hvps_pkg::t_cfg                i_cfg,
    output hvps_pkg::t_cls                     o_cls
);

    logic [hvps_pkg::RUN_BITS-1:0] r_high_run;
    logic [hvps_pkg::RUN_BITS-1:0] r_low_run;
    logic                          r_empty_flag;
    logic [hvps_pkg::RUN_BITS-1:0] n_high_run;
    logic [hvps_pkg::RUN_BITS-1:0] n_low_run;
    logic                          n_empty_flag;

    // Saturating run counters and the flag they flip.
    always_comb begin
        n_high_run   = r_high_run;
        n_low_run    = r_low_run;
        n_empty_flag = r_empty_flag;
        if (i_tank_sense_high) begin
            if (r_high_run != '1) begin
                n_high_run = r_high_run + 1'b1;
            end
            n_low_run = '0;
            if (n_high_run >= i_cfg.settle_count) begin
                n_empty_flag = 1'b1;
            end
        end else begin
            if (r_low_run != '1) begin
                n_low_run = r_low_run + 1'b1;
            end
            n_high_run = '0;
            if (n_low_run >= i_cfg.settle_count) begin
                n_empty_flag = 1'b0;
            end
        end
    end

    // Classification handed to the queue on the accepting edge.
    always_comb begin
        o_cls.water_empty = n_empty_flag;
        o_cls.target      = (i_humidity_tenths >= i_cfg.rh_setpoint);
    end

    // Debounce state advances only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_run   <= '0;
            r_low_run    <= '0;
            r_empty_flag <= 1'b0;
        end else if (i_take) begin
            r_high_run   <= n_high_run;
            r_low_run    <= n_low_run;
            r_empty_flag <= n_empty_flag;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hvps_cls_queue.sv -----
// Two-entry queue of classified ticks between the front and the back.
// Depends on hvps_pkg for the t_cls type.
`timescale 1ns / 1ps
`default_nettype none

module hvps_cls_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hvps_pkg::t_cls i_data,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output hvps_pkg::t_cls      o_head
);

    hvps_pkg::t_cls r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hvps_res_queue.sv -----
// Two-entry result queue that drives the output side of the block.
// Depends on hvps_pkg for the t_result type.
`timescale 1ns / 1ps
`default_nettype none

module hvps_res_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hvps_pkg::t_result i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output hvps_pkg::t_result      o_head
);

    hvps_pkg::t_result r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hvps_back.sv -----
// Back end: applies the valve and pump priority rules to one classified tick.
// Depends on hvps_pkg for the configuration, classification and result types.
`timescale 1ns / 1ps
`default_nettype none

module hvps_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire hvps_pkg::t_cls    i_cls,
    input  wire hvps_pkg::t_cfg    i_cfg,
    output hvps_pkg::t_result      o_result
);

    logic                            r_valve_active;
    logic                            r_pump_active;
    logic                            r_valve_done;
    logic [1:0]                      r_phase;
    logic [hvps_pkg::TIMER_BITS-1:0] r_countdown;
    logic                            n_valve_active;
    logic                            n_pump_active;
    logic                            n_valve_done;
    logic [1:0]                      n_phase;
    logic [hvps_pkg::TIMER_BITS-1:0] n_countdown;
    logic                            cd_zero;

    assign cd_zero = (r_countdown == '0);

    // Priority rules: target, open valve, empty tank, pump cycle, empty after fill.
    always_comb begin
        n_valve_active = r_valve_active;
        n_pump_active  = r_pump_active;
        n_valve_done   = r_valve_done;
        n_phase        = r_phase;
        n_countdown    = r_countdown;
        if (i_cls.target) begin
            if (r_valve_active) begin
                n_valve_active = 1'b0;
                n_countdown    = '0;
            end
            if (r_pump_active) begin
                n_pump_active = 1'b0;
                n_phase       = hvps_pkg::PH_IDLE;
                n_countdown   = '0;
            end
        end else if (r_valve_active) begin
            if (r_pump_active) begin
                n_pump_active = 1'b0;
                n_phase       = hvps_pkg::PH_IDLE;
            end
            if (!cd_zero) begin
                n_countdown = r_countdown - 1'b1;
            end else begin
                n_valve_active = 1'b0;
                n_valve_done   = 1'b1;
            end
        end else if (i_cls.water_empty && !r_valve_done) begin
            if (r_pump_active) begin
                n_pump_active = 1'b0;
                n_phase       = hvps_pkg::PH_IDLE;
            end
            n_valve_active = 1'b1;
            n_countdown    = i_cfg.valve_fill_ticks;
        end else if (!i_cls.water_empty) begin
            n_valve_done = 1'b0;
            case (r_phase)
                hvps_pkg::PH_RUN: begin
                    if (!cd_zero) begin
                        n_countdown = r_countdown - 1'b1;
                    end else begin
                        n_pump_active = 1'b0;
                        n_countdown   = i_cfg.pump_wait_ticks;
                        n_phase       = hvps_pkg::PH_WAIT;
                    end
                end
                hvps_pkg::PH_WAIT: begin
                    if (!cd_zero) begin
                        n_countdown = r_countdown - 1'b1;
                    end else begin
                        n_phase = hvps_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_pump_active = 1'b1;
                    n_countdown   = i_cfg.pump_run_ticks;
                    n_phase       = hvps_pkg::PH_RUN;
                end
            endcase
        end else begin
            if (r_pump_active) begin
                n_pump_active = 1'b0;
                n_phase       = hvps_pkg::PH_IDLE;
            end
        end
    end

    // Result is taken from the updated state.
    always_comb begin
        o_result.valve_open     = n_valve_active;
        o_result.pump_duty      = n_pump_active ? i_cfg.pump_run_duty : '0;
        o_result.water_empty    = i_cls.water_empty;
        o_result.pump_phase     = n_phase;
        o_result.ticks_left     = n_countdown;
        o_result.target_reached = i_cls.target;
    end

    // Control state advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_active <= 1'b0;
            r_pump_active  <= 1'b0;
            r_valve_done   <= 1'b0;
            r_phase        <= hvps_pkg::PH_IDLE;
            r_countdown    <= '0;
        end else if (i_go) begin
            r_valve_active <= n_valve_active;
            r_pump_active  <= n_pump_active;
            r_valve_done   <= n_valve_done;
            r_phase        <= n_phase;
            r_countdown    <= n_countdown;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the humidifier valve and pump sequencer.
// Holds a cycle-free predictor of the debounce and control rules and checks each status.
// Depends on hvps_pkg and humidifier_valve_pump_sequencer from the rtl folder.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_CYCLES   = 300;
    localparam int IDLE_PCT       = 15;

    // Local names for the package widths used in casts.
    localparam int HUM_W   = hvps_pkg::HUM_BITS;
    localparam int CFG_W   = hvps_pkg::CFG_BITS;
    localparam int FIELD_W = hvps_pkg::TIMER_BITS;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [hvps_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [hvps_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // Humidity values used by the directed tests.
    localparam logic signed [HUM_W-1:0] HUM_MIN        = 11'h400;
    localparam logic signed [HUM_W-1:0] HUM_MAX        = 11'sd1023;
    localparam logic signed [HUM_W-1:0] HUM_BELOW_MAX  = 11'sd1022;
    localparam logic signed [HUM_W-1:0] HUM_ZERO       = 11'sd0;
    localparam logic signed [HUM_W-1:0] HUM_LOW_SET    = 11'sd300;
    localparam logic signed [HUM_W-1:0] HUM_JUST_UNDER = 11'sd499;

    // Clock, reset and block inputs, all known from time zero.
    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   push = 1'b0;
    logic                                   pop = 1'b0;
    logic                                   i_tank_sense_high = 1'b0;
    logic signed [HUM_W-1:0]                i_humidity_tenths = '0;
    logic                                   i_cfg_we = 1'b0;
    logic [hvps_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx = '0;
    logic [CFG_W-1:0]                       i_cfg_data = '0;

    logic                                   full;
    logic                                   empty;
    logic                                   o_valve_open;
    logic [hvps_pkg::DUTY_BITS-1:0]         o_pump_duty;
    logic                                   o_water_empty;
    logic [1:0]                             o_pump_phase;
    logic [hvps_pkg::TIMER_BITS-1:0]        o_ticks_left;
    logic                                   o_target_reached;

    // Shadow copy of the configuration registers, starting from their reset values.
    logic signed [HUM_W-1:0]                cfg_preset   = hvps_pkg::PRESET_RST;
    logic [hvps_pkg::RUN_BITS-1:0]          cfg_debounce = hvps_pkg::DEBOUNCE_RST;
    logic [hvps_pkg::TIMER_BITS-1:0]        cfg_valve    = hvps_pkg::VALVE_RST;
    logic [hvps_pkg::TIMER_BITS-1:0]        cfg_run      = hvps_pkg::PUMP_RUN_RST;
    logic [hvps_pkg::TIMER_BITS-1:0]        cfg_wait     = hvps_pkg::PUMP_WAIT_RST;
    logic [hvps_pkg::DUTY_BITS-1:0]         cfg_duty     = hvps_pkg::DUTY_RST;

    // Predicted sequencer state.
    logic                                   empty_flag   = 1'b0;
    logic [hvps_pkg::RUN_BITS-1:0]          high_run     = '0;
    logic [hvps_pkg::RUN_BITS-1:0]          low_run      = '0;
    logic                                   valve_active = 1'b0;
    logic                                   pump_active  = 1'b0;
    logic                                   valve_done   = 1'b0;
    logic [1:0]                             cycle_phase  = hvps_pkg::PH_IDLE;
    logic [hvps_pkg::TIMER_BITS-1:0]        countdown    = '0;

    hvps_pkg::t_result pending_status[$];

    int send_idle_pct = IDLE_PCT;
    int pop_idle_pct  = IDLE_PCT;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int ticks_sent    = 0;
    int status_seen   = 0;
    int reg_writes    = 0;

    humidifier_valve_pump_sequencer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_tank_sense_high (i_tank_sense_high),
        .i_humidity_tenths (i_humidity_tenths),
        .empty             (empty),
        .pop               (pop),
        .o_valve_open      (o_valve_open),
        .o_pump_duty       (o_pump_duty),
        .o_water_empty     (o_water_empty),
        .o_pump_phase      (o_pump_phase),
        .o_ticks_left      (o_ticks_left),
        .o_target_reached  (o_target_reached),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one tick to the predicted state and queues the status it should produce.
    task automatic step_sequencer(input logic sense, input logic signed [HUM_W-1:0] hum);
        hvps_pkg::t_result r;
        logic              target;
        // The level pin is debounced first; the counters saturate.
        if (sense) begin
            if (high_run != {hvps_pkg::RUN_BITS{1'b1}}) high_run = high_run + 1'b1;
            low_run = '0;
            if (high_run >= cfg_debounce && !empty_flag) empty_flag = 1'b1;
        end else begin
            if (low_run != {hvps_pkg::RUN_BITS{1'b1}}) low_run = low_run + 1'b1;
            high_run = '0;
            if (low_run >= cfg_debounce && empty_flag) empty_flag = 1'b0;
        end
        target = (hum >= cfg_preset);

        // Control rules in priority order: target, open valve, empty tank, pump cycle, empty after fill.
        if (target) begin
            // Only what is active gets stopped; a waiting phase keeps its countdown.
            if (valve_active) begin
                valve_active = 1'b0;
                countdown = '0;
            end
            if (pump_active) begin
                pump_active = 1'b0;
                cycle_phase = hvps_pkg::PH_IDLE;
                countdown = '0;
            end
        end else if (valve_active) begin
            if (pump_active) begin
                pump_active = 1'b0;
                cycle_phase = hvps_pkg::PH_IDLE;
            end
            if (countdown != 0) begin
                countdown = countdown - 1'b1;
            end else begin
                valve_active = 1'b0;
                valve_done = 1'b1;
            end
        end else if (empty_flag && !valve_done) begin
            if (pump_active) begin
                pump_active = 1'b0;
                cycle_phase = hvps_pkg::PH_IDLE;
            end
            valve_active = 1'b1;
            countdown = cfg_valve;
        end else if (!empty_flag) begin
            valve_done = 1'b0;
            case (cycle_phase)
                hvps_pkg::PH_RUN: begin
                    if (countdown != 0) begin
                        countdown = countdown - 1'b1;
                    end else begin
                        pump_active = 1'b0;
                        countdown = cfg_wait;
                        cycle_phase = hvps_pkg::PH_WAIT;
                    end
                end
                hvps_pkg::PH_WAIT: begin
                    if (countdown != 0) countdown = countdown - 1'b1;
                    else cycle_phase = hvps_pkg::PH_IDLE;
                end
                default: begin
                    pump_active = 1'b1;
                    countdown = cfg_run;
                    cycle_phase = hvps_pkg::PH_RUN;
                end
            endcase
        end else if (pump_active) begin
            pump_active = 1'b0;
            cycle_phase = hvps_pkg::PH_IDLE;
        end

        r.valve_open     = valve_active;
        r.pump_duty      = pump_active ? cfg_duty : '0;
        r.water_empty    = empty_flag;
        r.pump_phase     = cycle_phase;
        r.ticks_left     = countdown;
        r.target_reached = target;
        pending_status.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Status checker and receiver: compares each accepted status, then picks the next pop.
    always @(posedge i_clk) begin : status_rx
        hvps_pkg::t_result want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                status_seen++;
                if (pending_status.size() == 0) begin
                    $error("status request with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = pending_status.pop_front();
                    check_field("valve_open", FIELD_W'(want.valve_open),
                                FIELD_W'(o_valve_open));
                    check_field("pump_duty", FIELD_W'(want.pump_duty),
                                FIELD_W'(o_pump_duty));
                    check_field("water_empty", FIELD_W'(want.water_empty),
                                FIELD_W'(o_water_empty));
                    check_field("pump_phase", FIELD_W'(want.pump_phase),
                                FIELD_W'(o_pump_phase));
                    check_field("ticks_left", want.ticks_left, o_ticks_left);
                    check_field("target_reached", FIELD_W'(want.target_reached),
                                FIELD_W'(o_target_reached));
                end
            end
            // A long hold-off is counted down here; otherwise pop idles at random.
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                pop <= ($urandom_range(99) >= pop_idle_pct);
            end
        end
    end

    // Ends the run when neither side has moved a request for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one tick request, idling at random first, and predicts it once accepted.
    task automatic send_tick(input logic sense, input logic signed [HUM_W-1:0] hum);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_tank_sense_high <= sense;
        i_humidity_tenths <= hum;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        step_sequencer(sense, hum);
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every predicted status has come back.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
    endtask

    // Writes one register while the block is idle and mirrors it into the shadow copy.
    task automatic write_reg(input logic [hvps_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            hvps_pkg::CFG_PRESET:    cfg_preset   = data[HUM_W-1:0];
            hvps_pkg::CFG_DEBOUNCE:  cfg_debounce = data[hvps_pkg::RUN_BITS-1:0];
            hvps_pkg::CFG_VALVE:     cfg_valve    = data[hvps_pkg::TIMER_BITS-1:0];
            hvps_pkg::CFG_PUMP_RUN:  cfg_run      = data[hvps_pkg::TIMER_BITS-1:0];
            hvps_pkg::CFG_PUMP_WAIT: cfg_wait     = data[hvps_pkg::TIMER_BITS-1:0];
            hvps_pkg::CFG_DUTY:      cfg_duty     = data[hvps_pkg::DUTY_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Humidity mostly near the preset, from 30 below to 10 above it, sometimes anywhere in range.
    function automatic logic signed [HUM_W-1:0] pick_humidity();
        int h;
        if ($urandom_range(9) == 0) return HUM_W'($urandom_range(2047));
        h = cfg_preset;
        h = h + int'($urandom_range(40)) - 30;
        if (h < -1024) h = -1024;
        if (h > 1023) h = 1023;
        return h[HUM_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0: return '0;
            1: return {CFG_W{1'b1}};
            2: return CFG_W'($urandom_range(4095));
            default: return CFG_W'($urandom_range(12));
        endcase
    endfunction

    // Sense episodes: the pin holds a level for a while with occasional one-tick glitches.
    task automatic run_episodes(input int count);
        int   left;
        int   len;
        logic level;
        logic glitch;
        left = count;
        level = 1'($urandom_range(1));
        while (left > 0) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(300, 200) : $urandom_range(40, 1);
            level = ~level;
            for (int k = 0; k < len && left > 0; k++) begin
                glitch = ($urandom_range(19) == 0);
                send_tick(level ^ glitch, pick_humidity());
                left--;
            end
        end
    endtask

    // Reset values: pump start at minimum humidity, target at maximum humidity, preset exactly met.
    task automatic test_defaults();
        send_tick(1'b0, HUM_MIN);
        send_tick(1'b1, HUM_MAX);
        send_tick(1'b0, hvps_pkg::PRESET_RST);
    endtask

    // A debounce count of zero flips the flag on the first sample of a new level.
    task automatic test_debounce_zero();
        drain();
        write_reg(hvps_pkg::CFG_DEBOUNCE, 12'd0);
        send_tick(1'b1, HUM_ZERO);
        send_tick(1'b0, HUM_ZERO);
        send_tick(1'b1, hvps_pkg::PRESET_RST);
    endtask

    // Zero length loads: each phase and the valve end on the very next tick.
    task automatic test_zero_loads();
        drain();
        write_reg(hvps_pkg::CFG_VALVE, 12'd0);
        write_reg(hvps_pkg::CFG_PUMP_RUN, 12'd0);
        write_reg(hvps_pkg::CFG_PUMP_WAIT, 12'd0);
        write_reg(hvps_pkg::CFG_DEBOUNCE, 12'd1);
        repeat (4) send_tick(1'b0, HUM_ZERO);
        repeat (3) send_tick(1'b1, HUM_ZERO);
        send_tick(1'b0, HUM_ZERO);
    endtask

    // The duty register is followed at once while the pump runs; upper data bits drop.
    task automatic test_duty_change();
        drain();
        write_reg(hvps_pkg::CFG_PUMP_RUN, {CFG_W{1'b1}});
        write_reg(hvps_pkg::CFG_DUTY, {CFG_W{1'b1}});
        repeat (3) send_tick(1'b0, HUM_ZERO);
        drain();
        write_reg(hvps_pkg::CFG_DUTY, 12'd0);
        send_tick(1'b0, HUM_ZERO);
        drain();
        write_reg(hvps_pkg::CFG_DUTY, 12'h3A5);
        send_tick(1'b0, HUM_ZERO);
    endtask

    // Reaching the target during the wait phase keeps the phase and its countdown.
    task automatic test_target_in_wait();
        drain();
        write_reg(hvps_pkg::CFG_PUMP_RUN, 12'd0);
        write_reg(hvps_pkg::CFG_PUMP_WAIT, 12'd5);
        write_reg(hvps_pkg::CFG_PRESET, 12'd300);
        send_tick(1'b0, HUM_MAX);
        send_tick(1'b0, HUM_ZERO);
        send_tick(1'b0, HUM_ZERO);
        send_tick(1'b0, HUM_LOW_SET);
        send_tick(1'b0, HUM_ZERO);
    endtask

    // Preset at both ends of the signed range, the low one written with bit 11 set.
    task automatic test_preset_extremes();
        drain();
        write_reg(hvps_pkg::CFG_PRESET, 12'hC00);
        send_tick(1'b0, HUM_MIN);
        drain();
        write_reg(hvps_pkg::CFG_PRESET, 12'h3FF);
        send_tick(1'b0, HUM_BELOW_MAX);
        send_tick(1'b0, HUM_MAX);
    endtask

    // Writes past the last register must leave every setting alone.
    task automatic test_ignored_writes();
        drain();
        write_reg(hvps_pkg::CFG_PRESET, 12'd500);
        write_reg(REG_SPARE_LO, {CFG_W{1'b1}});
        write_reg(REG_SPARE_HI, 12'd0);
        send_tick(1'b0, HUM_ZERO);
        send_tick(1'b1, HUM_JUST_UNDER);
    endtask

    // A long high run drives the high run counter into saturation, then a low run follows.
    task automatic test_run_saturation();
        drain();
        write_reg(hvps_pkg::CFG_DEBOUNCE, {CFG_W{1'b1}});
        write_reg(hvps_pkg::CFG_VALVE, 12'd40);
        write_reg(hvps_pkg::CFG_PUMP_RUN, 12'd7);
        write_reg(hvps_pkg::CFG_PUMP_WAIT, 12'd3);
        repeat (270) send_tick(1'b1, pick_humidity());
        repeat (30) send_tick(1'b0, pick_humidity());
    endtask

    // The receiver holds off while ticks keep coming, so both queues fill and full rises.
    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        stall_left <= STALL_CYCLES;
        repeat (40) send_tick(1'($urandom_range(1)), pick_humidity());
        send_idle_pct = IDLE_PCT;
    endtask

    // Several random settings, each followed by random tank episodes.
    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            drain();
            // One phase runs with no idling on either side.
            send_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            pop_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
            write_reg(hvps_pkg::CFG_PRESET,
                      ($urandom_range(5) == 0) ? CFG_W'($urandom_range(4095))
                                               : CFG_W'($urandom_range(600, 200)));
            case ($urandom_range(7))
                0: write_reg(hvps_pkg::CFG_DEBOUNCE, 12'd255);
                1: write_reg(hvps_pkg::CFG_DEBOUNCE, CFG_W'($urandom_range(4095)));
                default: write_reg(hvps_pkg::CFG_DEBOUNCE, CFG_W'($urandom_range(6)));
            endcase
            write_reg(hvps_pkg::CFG_VALVE, pick_ticks());
            write_reg(hvps_pkg::CFG_PUMP_RUN, pick_ticks());
            write_reg(hvps_pkg::CFG_PUMP_WAIT, pick_ticks());
            write_reg(hvps_pkg::CFG_DUTY, CFG_W'($urandom_range(4095)));
            run_episodes(100);
        end
        send_idle_pct = IDLE_PCT;
        pop_idle_pct  = IDLE_PCT;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_debounce_zero();
        test_zero_loads();
        test_duty_change();
        test_target_in_wait();
        test_preset_extremes();
        test_ignored_writes();
        test_run_saturation();
        test_backpressure();
        test_random_settings();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d ticks and checked %0d status words across %0d register writes,",
                 ticks_sent, status_seen, reg_writes);
        $display("covering debounce corners, zero and full loads, stalls and tank episodes.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
